[rtl/i2da_pkg.sv]
// shared types and constants for the integer to decimal ascii converter
`default_nettype none
package i2da_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int BCD_W          = 4;
    localparam int CHAR_W         = 6;
    localparam int OUT_TDATA_W    = 8;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;

    // operation applied to every digit cell in the same cycle
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_CLEAR,
        CELL_DABBLE,
        CELL_SHIFT
    } t_cell_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_SKIP,
        S_EMIT
    } t_state;

endpackage
`default_nettype wire

[rtl/i2da_digit_cell.sv]
// one bcd digit cell: add-3 correction and shift, digit hand-over, clear or hold
`default_nettype none
module i2da_digit_cell
    import i2da_pkg::*;
(
    input  wire logic             i_clk,
    input  wire t_cell_op         i_op,
    input  wire logic             i_bit,
    input  wire logic [BCD_W-1:0] i_digit,
    output logic                  o_bit,
    output logic [BCD_W-1:0]      o_digit
);

    logic [BCD_W-1:0] r_digit;
    logic [BCD_W-1:0] n_digit;
    logic [BCD_W-1:0] w_adj;

    // digit of five or more gets 3 added so the shift carries correctly
    assign w_adj   = (r_digit >= BCD_W'(5)) ? r_digit + BCD_W'(3) : r_digit;
    assign o_bit   = w_adj[BCD_W-1];
    assign o_digit = r_digit;

    always_comb begin
        case (i_op)
            CELL_CLEAR:  n_digit = '0;
            CELL_DABBLE: n_digit = {w_adj[BCD_W-2:0], i_bit};
            CELL_SHIFT:  n_digit = i_digit;
            default:     n_digit = r_digit;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

endmodule
`default_nettype wire

[rtl/i2da_digit_chain.sv]
// row of bcd digit cells, least significant digit in cell 0
`default_nettype none
module i2da_digit_chain
    import i2da_pkg::*;
#(
    parameter int NUM_DIGITS = 10
) (
    input  wire logic        i_clk,
    input  wire t_cell_op    i_op,
    input  wire logic        i_bit,
    output logic [BCD_W-1:0] o_top_digit
);

    logic                  w_carry [NUM_DIGITS];
    logic [BCD_W-1:0]      w_digit [NUM_DIGITS];

    genvar k;
    generate
        for (k = 0; k < NUM_DIGITS; k++) begin : g_cell
            if (k == 0 && NUM_DIGITS == 1) begin : g_only
                i2da_digit_cell u_cell (
                    .i_clk   (i_clk),
                    .i_op    (i_op),
                    .i_bit   (i_bit),
                    .i_digit ('0),
                    .o_bit   (),
                    .o_digit (w_digit[k])
                );
                assign w_carry[k] = 1'b0;
            end else if (k == 0) begin : g_low
                i2da_digit_cell u_cell (
                    .i_clk   (i_clk),
                    .i_op    (i_op),
                    .i_bit   (i_bit),
                    .i_digit ('0),
                    .o_bit   (w_carry[k]),
                    .o_digit (w_digit[k])
                );
            end else if (k == NUM_DIGITS - 1) begin : g_high
                // carry out of the top digit is always zero
                i2da_digit_cell u_cell (
                    .i_clk   (i_clk),
                    .i_op    (i_op),
                    .i_bit   (w_carry[k-1]),
                    .i_digit (w_digit[k-1]),
                    .o_bit   (),
                    .o_digit (w_digit[k])
                );
                assign w_carry[k] = 1'b0;
            end else begin : g_mid
                i2da_digit_cell u_cell (
                    .i_clk   (i_clk),
                    .i_op    (i_op),
                    .i_bit   (w_carry[k-1]),
                    .i_digit (w_digit[k-1]),
                    .o_bit   (w_carry[k]),
                    .o_digit (w_digit[k])
                );
            end
        end
    endgenerate

    assign o_top_digit = w_digit[NUM_DIGITS-1];

endmodule
`default_nettype wire

[rtl/int_to_decimal_ascii.sv]
// top level: signed integer to decimal ascii text, one character per output item
// sequence: accept, one shift-and-correct step per magnitude bit through the digit chain,
//   then leading zeros skipped (at least one digit kept), then the sign and digit characters
// one item at a time: a new value is taken only in idle, once the last character of the
//   previous value is loaded into the output register
// reset: synchronous active-low, clears the sequencer and output valid; digits need none
`default_nettype none
module int_to_decimal_ascii
    import i2da_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // input item: [DATA_WIDTH-1:0] value, zero padded to whole bytes
    input  wire logic [((DATA_WIDTH + 7) / 8) * 8-1:0] i_s_tdata,
    input  wire logic                                  i_s_tvalid,
    output logic                                       o_s_tready,
    // output item: [5:0] character, [7:6] zero
    output logic [OUT_TDATA_W-1:0]                     o_m_tdata,
    output logic                                       o_m_tlast,
    output logic                                       o_m_tvalid,
    input  wire logic                                  i_m_tready
);

    // decimal digits of the largest magnitude 2^(DATA_WIDTH-1)
    localparam int NUM_DIGITS = ((DATA_WIDTH - 1) * 30103) / 100000 + 1;
    localparam int BCW        = $clog2(DATA_WIDTH + 1);
    localparam int DCW        = $clog2(NUM_DIGITS + 1);

    t_state                 r_state, n_state;
    logic [DATA_WIDTH-1:0]  r_mag, n_mag;
    logic                   r_neg, n_neg;
    logic [BCW-1:0]         r_bit_cnt, n_bit_cnt;
    logic [DCW-1:0]         r_dig_cnt, n_dig_cnt;
    logic [CHAR_W-1:0]      r_char, n_char;
    logic                   r_last, n_last;
    logic                   r_out_valid, n_out_valid;

    t_cell_op               w_op;
    logic [BCD_W-1:0]       w_top;
    logic [DATA_WIDTH-1:0]  w_raw;
    logic                   w_slot_free;

    assign w_raw       = i_s_tdata[DATA_WIDTH-1:0];
    // output register can take a character this cycle
    assign w_slot_free = !r_out_valid || i_m_tready;

    // digit chain: the magnitude enters msb first at cell 0, digits leave at the top cell
    i2da_digit_chain #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_chain (
        .i_clk       (i_clk),
        .i_op        (w_op),
        .i_bit       (r_mag[DATA_WIDTH-1]),
        .o_top_digit (w_top)
    );

    always_comb begin
        n_state     = r_state;
        n_mag       = r_mag;
        n_neg       = r_neg;
        n_bit_cnt   = r_bit_cnt;
        n_dig_cnt   = r_dig_cnt;
        n_char      = r_char;
        n_last      = r_last;
        n_out_valid = r_out_valid && !i_m_tready;
        w_op        = CELL_HOLD;
        o_s_tready  = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    // magnitude of the most negative value fits unsigned in the same width
                    n_neg     = w_raw[DATA_WIDTH-1];
                    n_mag     = w_raw[DATA_WIDTH-1] ? '0 - w_raw : w_raw;
                    n_bit_cnt = BCW'(DATA_WIDTH);
                    w_op      = CELL_CLEAR;
                    n_state   = S_CONV;
                end
            end
            S_CONV: begin
                w_op      = CELL_DABBLE;
                n_mag     = {r_mag[DATA_WIDTH-2:0], 1'b0};
                n_bit_cnt = r_bit_cnt - BCW'(1);
                if (r_bit_cnt == BCW'(1)) begin
                    n_dig_cnt = DCW'(NUM_DIGITS);
                    n_state   = S_SKIP;
                end
            end
            S_SKIP: begin
                // drop leading zeros, keeping at least one digit
                if (w_top == '0 && r_dig_cnt != DCW'(1)) begin
                    w_op      = CELL_SHIFT;
                    n_dig_cnt = r_dig_cnt - DCW'(1);
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    if (r_neg) begin
                        n_char = CHAR_MINUS;
                        n_last = 1'b0;
                        n_neg  = 1'b0;
                    end else begin
                        n_char    = CHAR_ZERO + CHAR_W'(w_top);
                        n_last    = (r_dig_cnt == DCW'(1));
                        w_op      = CELL_SHIFT;
                        n_dig_cnt = r_dig_cnt - DCW'(1);
                        if (r_dig_cnt == DCW'(1)) begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_neg       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_neg       <= n_neg;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag     <= n_mag;
        r_bit_cnt <= n_bit_cnt;
        r_dig_cnt <= n_dig_cnt;
        r_char    <= n_char;
        r_last    <= n_last;
    end

    assign o_m_tdata  = {(OUT_TDATA_W - CHAR_W)'(0), r_char};
    assign o_m_tlast  = r_last;
    assign o_m_tvalid = r_out_valid;

endmodule
`default_nettype wire

[tb/int_to_decimal_ascii_tb.sv]
// self-checking testbench for the signed integer to decimal ascii converter
`timescale 1ns / 1ps
module int_to_decimal_ascii_tb;
    import i2da_pkg::*;

    localparam int DATA_WIDTH  = 32;
    localparam int IN_W        = ((DATA_WIDTH + 7) / 8) * 8;
    localparam int N_DIRECTED  = 20;
    localparam int N_RANDOM    = 480;
    localparam int IDLE_LIMIT  = 3000;  // cycles with no item moving on either side
    localparam int LONG_HOLD   = 400;   // receiver hold-off that backs up the input
    localparam int DRAIN_WAIT  = 60;    // extra wait after the last expected character is checked

    // one expected output item: character code and end-of-text flag
    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              is_last;
    } t_text_char;

    logic            i_clk      = 1'b0;
    logic            i_rst_n    = 1'b0;
    logic [IN_W-1:0] i_s_tdata  = '0;   // [31:0] value
    logic            i_s_tvalid = 1'b0;
    logic            o_s_tready;
    logic [7:0]      o_m_tdata;         // [5:0] character, [7:6] zero
    logic            o_m_tlast;
    logic            o_m_tvalid;
    logic            i_m_tready = 1'b0;

    t_text_char pending_chars[$];
    int         error_count   = 0;
    int         values_sent   = 0;
    int         negatives     = 0;
    int         chars_checked = 0;
    int         long_holds    = 0;
    bit         hold_request  = 1'b0;

    // directed rows; an empty text means the predictor supplies the result
    logic [31:0] dir_value [N_DIRECTED] = '{
        32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0009, 32'h0000_000A,
        32'hFFFF_FFF7, 32'hFFFF_FFF6, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
        32'h3B9A_CA00, 32'hC465_3600, 32'h3B9A_C9FF, 32'h5555_5555, 32'hAAAA_AAAA,
        32'h0F0F_0F0F, 32'h0000_0063, 32'h0000_0064, 32'h8000_FFFF, 32'hF0F0_F0F0
    };
    string dir_text [N_DIRECTED] = '{
        "0", "1", "-1", "9", "10",
        "-9", "-10", "2147483647", "-2147483648", "-2147483647",
        "1000000000", "-1000000000", "", "", "",
        "", "", "", "", ""
    };

    int_to_decimal_ascii #(
        .DATA_WIDTH (DATA_WIDTH)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready)
    );

    initial begin
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    // queue the decimal text of one value, sign first, no leading zeros
    function automatic void push_decimal_text(input logic [DATA_WIDTH-1:0] value);
        logic [DATA_WIDTH-1:0] mag;
        logic [3:0]            digit_buf [0:23];
        longint unsigned       rest;
        int                    n_dig;
        // two's complement negate; the most negative value maps onto its own bits
        mag   = value[DATA_WIDTH-1] ? -value : value;
        rest  = mag;
        n_dig = 0;
        do begin
            digit_buf[n_dig] = 4'(rest % 10);
            rest             = rest / 10;
            n_dig++;
        end while (rest != 0);
        if (value[DATA_WIDTH-1]) begin
            pending_chars.push_back('{CHAR_MINUS, 1'b0});
        end
        for (int i = n_dig - 1; i >= 0; i--) begin
            pending_chars.push_back('{CHAR_ZERO + CHAR_W'(digit_buf[i]), i == 0});
        end
    endfunction

    function automatic void push_typed_text(input string text);
        byte c;
        for (int k = 0; k < text.len(); k++) begin
            c = text[k];
            pending_chars.push_back('{c[CHAR_W-1:0], k == text.len() - 1});
        end
    endfunction

    function automatic int pick_gap(input bit no_idle);
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 70) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // random values spread over text lengths, digit boundaries and the extremes
    function automatic logic [31:0] random_value();
        longint unsigned scale;
        longint unsigned mag;
        int              r;
        int              n_dig;
        r = $urandom_range(0, 9);
        if (r < 4) return $urandom;
        if (r == 9) begin
            if ($urandom_range(0, 1) == 1) return 32'h7FFF_FFFF - $urandom_range(0, 3);
            return 32'h8000_0000 + $urandom_range(0, 3);
        end
        n_dig = $urandom_range(1, 10);
        scale = 1;
        for (int k = 0; k < n_dig; k++) scale = scale * 10;
        if (r == 8) begin
            // just around a power of ten
            mag = scale / 10 + $urandom_range(0, 2);
            if (mag > 0) mag = mag - 1;
        end else begin
            mag = {$urandom, $urandom} % scale;
        end
        if (mag > 64'h7FFF_FFFF) mag = mag % 64'h8000_0000;
        if ($urandom_range(0, 1) == 1) return -mag[31:0];
        return mag[31:0];
    endfunction

    // offer one value until the block takes it, then maybe leave a gap
    task automatic send_value(input logic [31:0] value, input string text, input bit no_idle);
        int gap;
        i_s_tdata  <= value;
        i_s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        if (text.len() > 0) push_typed_text(text);
        else push_decimal_text(value);
        values_sent++;
        if (value[31]) negatives++;
        gap = pick_gap(no_idle);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata  <= $urandom;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // output side: check each accepted character, then pick the next ready level
    initial begin
        t_text_char want;
        int         ready_run;
        bit         ready_level;
        int         r;
        ready_run   = 0;
        ready_level = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready) begin
                chars_checked++;
                if (pending_chars.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected character: got %0d last %0b", $time,
                             o_m_tdata[CHAR_W-1:0], o_m_tlast);
                end else begin
                    want = pending_chars.pop_front();
                    if (o_m_tdata[CHAR_W-1:0] !== want.code || o_m_tlast !== want.is_last ||
                        o_m_tdata[7:CHAR_W] !== '0) begin
                        error_count++;
                        $display("%0t: expected char %0d last %0b, got %0d last %0b pad %b",
                                 $time, want.code, want.is_last, o_m_tdata[CHAR_W-1:0],
                                 o_m_tlast, o_m_tdata[7:CHAR_W]);
                    end
                end
            end
            if (hold_request) begin
                // long hold-off so the converter fills up and refuses input
                hold_request = 1'b0;
                ready_level  = 1'b0;
                ready_run    = LONG_HOLD;
                long_holds++;
            end else if (ready_run == 0) begin
                r = $urandom_range(0, 99);
                if (r < 50) begin
                    ready_level = 1'b1;
                    ready_run   = $urandom_range(1, 20);
                end else if (r < 55) begin
                    ready_level = 1'b1;
                    ready_run   = $urandom_range(50, 150);
                end else if (r < 90) begin
                    ready_level = 1'b0;
                    ready_run   = $urandom_range(1, 3);
                end else if (r < 98) begin
                    ready_level = 1'b0;
                    ready_run   = $urandom_range(4, 12);
                end else begin
                    ready_level = 1'b0;
                    ready_run   = $urandom_range(20, 60);
                end
            end
            i_m_tready <= ready_level;
            ready_run--;
        end
    end

    // watchdog on cycles where no item moves on either side
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || !i_rst_n)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: timeout, %0d characters still expected", $time, pending_chars.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int n = 0; n < N_DIRECTED; n++) begin
            send_value(dir_value[n], dir_text[n], 1'b0);
        end

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == 120) hold_request = 1'b1;
            // every third stretch of 60 values runs with no input gaps
            send_value(random_value(), "", (n / 60) % 3 == 1);
        end
        i_s_tvalid <= 1'b0;

        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("converted %0d integers (%0d negative, extremes included), %0d characters checked",
                 values_sent, negatives, chars_checked);
        $display("output held off %0d time(s) for %0d cycles with input backed up",
                 long_holds, LONG_HOLD);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/i2da_pkg.sv
rtl/i2da_digit_cell.sv
rtl/i2da_digit_chain.sv
rtl/int_to_decimal_ascii.sv
tb/int_to_decimal_ascii_tb.sv
